// ----- hdl/aps_pkg.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler package
// Shared sizes, operation and register codes, and the structs passed between
// the sequencer, the shared arithmetic unit and the task table.
// ----------------------------------------------------------------------------
package aps_pkg;

   // table sizing
   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // field widths
   localparam int ID_W   = 8;
   localparam int TICK_W = 16;
   localparam int PRIO_W = 16;
   localparam int INC_W  = 4;

   // operation codes
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // configuration register indexes
   localparam int   CSR_ADDR_W   = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_INC  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WAIT_INC = 1'b1;

   // request to the shared add / compare unit
   typedef struct packed {
      logic              sub;   // 1: compare a against b, 0: saturating a + b
      logic [PRIO_W-1:0] a;
      logic [PRIO_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [PRIO_W-1:0] sum_sat;
      logic              lt;    // a < b
      logic              eq;    // a == b
   } alu_rsp_type;

   // table command from the sequencer
   typedef struct packed {
      logic              ins;
      logic [IDX_W-1:0]  ins_pos;
      logic [ID_W-1:0]   ins_id;
      logic [TICK_W-1:0] ins_rem;
      logic [PRIO_W-1:0] ins_pri;
      logic              mov;     // entry[mov_idx-1] <= entry[mov_idx], new priority
      logic [IDX_W-1:0]  mov_idx;
      logic [PRIO_W-1:0] mov_pri;
      logic              pop;     // drop one from the entry count
   } tbl_cmd_type;

endpackage

// ----- hdl/aps_alu.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler shared arithmetic unit
// One 17-bit adder serves both the saturating priority add and the
// priority compare used by the insertion scan.
// ----------------------------------------------------------------------------
module aps_alu (
   input  aps_pkg::alu_req_type req,
   output aps_pkg::alu_rsp_type rsp
);
   import aps_pkg::*;

   logic [PRIO_W-1:0] b_eff;
   logic [PRIO_W:0]   total;

   // invert and carry in for a subtract
   assign b_eff = req.sub ? ~req.b : req.b;
   assign total = {1'b0, req.a} + {1'b0, b_eff} + {{PRIO_W{1'b0}}, req.sub};

   // saturate on carry out, flag borrow and zero difference
   assign rsp.sum_sat = total[PRIO_W] ? {PRIO_W{1'b1}} : total[PRIO_W-1:0];
   assign rsp.lt      = ~total[PRIO_W];
   assign rsp.eq      = (total[PRIO_W-1:0] == '0);

endmodule

// ----- hdl/aps_table.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler task table
// Ordered entries of id, remaining ticks and priority, with an entry count.
// Supports insert with shift, move of one entry towards the head, and pop.
// ----------------------------------------------------------------------------
module aps_table (
   input  logic                      clock,
   input  logic                      reset,
   input  aps_pkg::tbl_cmd_type      cmd,
   input  logic [aps_pkg::IDX_W-1:0] rd_idx,
   output logic [aps_pkg::PRIO_W-1:0] rd_pri,
   output logic [aps_pkg::ID_W-1:0]   head_id,
   output logic [aps_pkg::TICK_W-1:0] head_rem,
   output logic [aps_pkg::PRIO_W-1:0] head_pri,
   output logic [aps_pkg::CNT_W-1:0]  count
);
   import aps_pkg::*;

   logic [ID_W-1:0]   id_ff  [MAX_TASKS];
   logic [TICK_W-1:0] rem_ff [MAX_TASKS];
   logic [PRIO_W-1:0] pri_ff [MAX_TASKS];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   // read ports
   assign rd_pri   = pri_ff[rd_idx];
   assign head_id  = id_ff[0];
   assign head_rem = rem_ff[0];
   assign head_pri = pri_ff[0];
   assign count    = count_ff;

   // update each entry from its neighbours
   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_entry
      localparam int PREV = (g == 0) ? 0 : g - 1;
      localparam int NEXT = (g == MAX_TASKS - 1) ? g : g + 1;

      always_ff @(posedge clock) begin
         if (cmd.ins && (IDX_W'(g) == cmd.ins_pos)) begin
            id_ff[g]  <= cmd.ins_id;
            rem_ff[g] <= cmd.ins_rem;
            pri_ff[g] <= cmd.ins_pri;
         end else if (cmd.ins && (g > 0) && (IDX_W'(g) > cmd.ins_pos)) begin
            id_ff[g]  <= id_ff[PREV];
            rem_ff[g] <= rem_ff[PREV];
            pri_ff[g] <= pri_ff[PREV];
         end else if (cmd.mov && ({1'b0, cmd.mov_idx} == (IDX_W + 1)'(g + 1))) begin
            id_ff[g]  <= id_ff[NEXT];
            rem_ff[g] <= rem_ff[NEXT];
            pri_ff[g] <= cmd.mov_pri;
         end
      end
   end

   // track the fill level
   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- hdl/aging_priority_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// Aging priority scheduler unit
// Ordered task table with aging. A sequencer drives one shared add/compare
// unit over the table, one entry per cycle, for aging and insertion scans.
// ----------------------------------------------------------------------------
// Sequence: a drop or an empty tick goes straight to the output stage; an arrive runs
// the insertion scan, and a served tick runs the aging sweep and then, unless the task
// finished, the insertion scan; the result is registered once the output is free.
// Throughput: one transaction at a time; req_tready is high only when idle.
// Reset: synchronous, clears the table count, the sequencer and the output
// register, and loads the increments with 1 (running) and 2 (waiting).
module aging_priority_scheduler_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // task_id[7:0], burst_ticks[23:8]
   input  logic                          req_tuser,  // operation[0]
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // served_id[7:0], served_finished[8],
                                                     // arrival_dropped[9], zero[15:10]
   output logic                          rsp_tuser,  // served_valid[0]
   // configuration port
   input  logic                          csr_we,
   input  logic [aps_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [aps_pkg::INC_W-1:0]     csr_wdata
);
   import aps_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_AGE  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [INC_W-1:0]  run_inc_ff, run_inc_in;
   logic [INC_W-1:0]  wait_inc_ff, wait_inc_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ID_W-1:0]   hold_id_ff, hold_id_in;
   logic [TICK_W-1:0] hold_rem_ff, hold_rem_in;
   logic [PRIO_W-1:0] hold_pri_ff, hold_pri_in;
   logic              res_valid_ff, res_valid_in;
   logic              res_fin_ff, res_fin_in;
   logic              res_drop_ff, res_drop_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_fin_ff, rsp_fin_in;
   logic              rsp_drop_ff, rsp_drop_in;

   logic              req_op;
   logic [ID_W-1:0]   req_id;
   logic [TICK_W-1:0] req_burst;
   logic              accept;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   tbl_cmd_type       tbl_cmd;
   logic [IDX_W-1:0]  rd_idx;
   logic [PRIO_W-1:0] rd_pri;
   logic [ID_W-1:0]   head_id;
   logic [TICK_W-1:0] head_rem;
   logic [PRIO_W-1:0] head_pri;
   logic [CNT_W-1:0]  count;

   // unpack the request
   assign req_op    = req_tuser;
   assign req_id    = req_tdata[7:0];
   assign req_burst = req_tdata[23:8];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // pack the result
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_drop_ff, rsp_fin_ff, rsp_id_ff};

   aps_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   aps_table u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .rd_idx   (rd_idx),
      .rd_pri   (rd_pri),
      .head_id  (head_id),
      .head_rem (head_rem),
      .head_pri (head_pri),
      .count    (count)
   );

   // take configuration writes
   always_comb begin
      run_inc_in  = run_inc_ff;
      wait_inc_in = wait_inc_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_RUN_INC:  run_inc_in  = csr_wdata;
            CSR_WAIT_INC: wait_inc_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      hold_id_in    = hold_id_ff;
      hold_rem_in   = hold_rem_ff;
      hold_pri_in   = hold_pri_ff;
      res_valid_in  = res_valid_ff;
      res_fin_in    = res_fin_ff;
      res_drop_in   = res_drop_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_drop_in   = rsp_drop_ff;

      alu_req     = '0;
      tbl_cmd     = '0;
      rd_idx      = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_valid_in = 1'b0;
               res_fin_in   = 1'b0;
               res_drop_in  = 1'b0;
               hold_id_in   = '0;
               if (req_op == OP_ARRIVE) begin
                  if (count == CNT_W'(MAX_TASKS)) begin
                     res_drop_in = 1'b1;
                     state_in    = S_DONE;
                  end else begin
                     hold_id_in  = req_id;
                     hold_rem_in = req_burst;
                     hold_pri_in = '0;
                     idx_in      = '0;
                     state_in    = S_SCAN;
                  end
               end else if (count == '0) begin
                  state_in = S_DONE;
               end else begin
                  // capture the head and start the aging sweep
                  hold_id_in  = head_id;
                  hold_rem_in = (head_rem == '0) ? '0 : head_rem - TICK_W'(1);
                  hold_pri_in = head_pri;
                  k_in        = CNT_W'(1);
                  state_in    = S_AGE;
               end
            end
         end

         S_AGE: begin
            alu_req.sub = 1'b0;
            rd_idx      = k_ff[IDX_W-1:0];
            if (k_ff < count) begin
               // advance one waiting entry towards the head and age it
               alu_req.a       = rd_pri;
               alu_req.b       = PRIO_W'(wait_inc_ff);
               tbl_cmd.mov     = 1'b1;
               tbl_cmd.mov_idx = k_ff[IDX_W-1:0];
               tbl_cmd.mov_pri = alu_rsp.sum_sat;
               k_in            = k_ff + CNT_W'(1);
            end else begin
               // drop the served head and raise its priority
               alu_req.a    = hold_pri_ff;
               alu_req.b    = PRIO_W'(run_inc_ff);
               tbl_cmd.pop  = 1'b1;
               hold_pri_in  = alu_rsp.sum_sat;
               res_valid_in = 1'b1;
               res_fin_in   = (hold_rem_ff == '0);
               idx_in       = '0;
               state_in     = (hold_rem_ff == '0) ? S_DONE : S_SCAN;
            end
         end

         S_SCAN: begin
            alu_req.sub     = 1'b1;
            alu_req.a       = rd_pri;
            alu_req.b       = hold_pri_ff;
            tbl_cmd.ins_id  = hold_id_ff;
            tbl_cmd.ins_rem = hold_rem_ff;
            tbl_cmd.ins_pri = hold_pri_ff;
            tbl_cmd.ins_pos = idx_ff;
            if (idx_ff == '0) begin
               // head rules: go ahead of a lower head, just behind an equal one
               if (count == '0 || alu_rsp.lt) begin
                  tbl_cmd.ins = 1'b1;
                  state_in    = S_DONE;
               end else if (alu_rsp.eq) begin
                  tbl_cmd.ins     = 1'b1;
                  tbl_cmd.ins_pos = IDX_W'(1);
                  state_in        = S_DONE;
               end else begin
                  idx_in = IDX_W'(1);
               end
            end else if (({1'b0, idx_ff} >= count) || alu_rsp.lt || alu_rsp.eq) begin
               // stop ahead of the first entry not above the new priority
               tbl_cmd.ins = 1'b1;
               state_in    = S_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         S_DONE: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_valid_in  = res_valid_ff;
               rsp_id_in     = res_valid_ff ? hold_id_ff : '0;
               rsp_fin_in    = res_fin_ff;
               rsp_drop_in   = res_drop_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         run_inc_ff    <= INC_W'(1);
         wait_inc_ff   <= INC_W'(2);
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         run_inc_ff    <= run_inc_in;
         wait_inc_ff   <= wait_inc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      idx_ff       <= idx_in;
      hold_id_ff   <= hold_id_in;
      hold_rem_ff  <= hold_rem_in;
      hold_pri_ff  <= hold_pri_in;
      res_valid_ff <= res_valid_in;
      res_fin_ff   <= res_fin_in;
      res_drop_ff  <= res_drop_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

endmodule
